// File: rtl/vcfc_pkg.sv
package vcfc_pkg;

  localparam int FRAME_MAX     = 9;
  localparam int LEN_W         = 4;
  localparam int STORE_DEPTH   = 9;
  localparam int REPLY_MAX_DEF = 32;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] VER1_CODE = 8'h01;
  localparam logic [7:0] VER2_CODE = 8'h09;
  localparam logic [7:0] RSV_BYTE  = 8'h01;
  localparam logic [7:0] CRC_POLY  = 8'hD5;

  localparam logic [2:0] CMD_GET   = 3'd1;
  localparam logic [2:0] CMD_POWER = 3'd2;
  localparam logic [2:0] CMD_CHAN  = 3'd3;
  localparam logic [2:0] CMD_FREQ  = 3'd4;
  localparam logic [2:0] CMD_MODE  = 3'd5;

  localparam logic [1:0] VER_UNKNOWN = 2'd0;
  localparam logic [1:0] VER_ONE     = 2'd1;
  localparam logic [1:0] VER_TWO     = 2'd2;

  localparam logic ACT_SEND  = 1'b0;
  localparam logic ACT_REPLY = 1'b1;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_RPT = 1'b1;

  typedef struct packed {
    logic [1:0]  version;
    logic [7:0]  channel;
    logic [7:0]  power;
    logic [7:0]  mode;
    logic [15:0] frequency;
  } settings_t;

  typedef logic [FRAME_MAX-1:0][7:0] frame_t;

  // crc-8 dvb-s2, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] v1_power(input logic [1:0] idx);
    logic [7:0] p;
    case (idx)
      2'd0:    p = 8'd7;
      2'd1:    p = 8'd16;
      2'd2:    p = 8'd25;
      default: p = 8'd40;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/vtx_control_frame_codec_core.sv
// results: an accepted item goes to the pending register, then to the out_* registers
// throughput: a send item stalls the input until its 4, 7, 8 or 9 frame bytes move out,
//   one per cycle from the frame buffer when out is free; the last reply byte adds a report
// reset: synchronous active-low rst_n clears the stored settings, the reply store,
//   count and crc, and drops all pending results
module vtx_control_frame_codec_core #(
  parameter int REPLY_MAX = vcfc_pkg::REPLY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_value,
  input  logic [7:0]  in_reply_byte,
  input  logic        in_reply_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  output logic        out_reply_ok,
  output logic [1:0]  out_device_version,
  output logic [7:0]  out_channel_now,
  output logic [7:0]  out_power_now,
  output logic [7:0]  out_mode_now,
  output logic [15:0] out_frequency_now
);
  import vcfc_pkg::*;

  logic             accept;
  logic             out_free;
  logic             move;
  logic             pend_last;
  frame_t           fb;
  logic [LEN_W-1:0] fb_len;
  settings_t        set_cur;
  settings_t        set_nxt;
  logic             dec_ok;

  logic             pend_busy_r;
  logic             pend_kind_r;
  logic [LEN_W-1:0] pend_len_r;
  logic [LEN_W-1:0] pend_idx_r;
  frame_t           pend_frame_r;
  settings_t        pend_set_r;
  logic             pend_ok_r;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [7:0]       out_byte_r;
  logic             out_end_r;
  logic             out_ok_r;
  settings_t        out_set_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign move      = pend_busy_r && out_free;
  assign pend_last = (pend_idx_r + LEN_W'(1)) == pend_len_r;
  assign in_stall  = pend_busy_r && !(move && pend_last);
  assign accept    = in_valid && !in_stall;

  vcfc_frame_build u_frame (
    .cmd     (in_command),
    .value   (in_value),
    .version (set_cur.version),
    .frame   (fb),
    .len     (fb_len)
  );

  vcfc_reply_dec #(
    .REPLY_MAX (REPLY_MAX)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (accept && in_action == ACT_REPLY),
    .cmd     (in_command),
    .rb      (in_reply_byte),
    .last    (in_reply_last),
    .set_cur (set_cur),
    .set_nxt (set_nxt),
    .ok      (dec_ok)
  );

  // pending item: a whole frame or one report, drained one result per cycle while out is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_busy_r <= 1'b0;
      pend_idx_r  <= '0;
    end else begin
      if (move) begin
        pend_idx_r <= pend_idx_r + LEN_W'(1);
        if (pend_last) begin
          pend_busy_r <= 1'b0;
        end
      end
      if (accept && (in_action == ACT_SEND || in_reply_last)) begin
        pend_busy_r <= 1'b1;
        pend_idx_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_action == ACT_SEND) begin
        pend_kind_r  <= KIND_TX;
        pend_len_r   <= fb_len;
        pend_frame_r <= fb;
      end else begin
        pend_kind_r  <= KIND_RPT;
        pend_len_r   <= LEN_W'(1);
      end
      pend_set_r <= set_nxt;
      pend_ok_r  <= dec_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind_r <= pend_kind_r;
      if (pend_kind_r == KIND_TX) begin
        out_byte_r <= pend_frame_r[pend_idx_r];
        out_end_r  <= pend_last;
        out_ok_r   <= 1'b0;
        out_set_r  <= '0;
      end else begin
        out_byte_r <= 8'd0;
        out_end_r  <= 1'b0;
        out_ok_r   <= pend_ok_r;
        out_set_r  <= pend_set_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_tx_byte        = out_byte_r;
  assign out_frame_end      = out_end_r;
  assign out_reply_ok       = out_ok_r;
  assign out_device_version = out_set_r.version;
  assign out_channel_now    = out_set_r.channel;
  assign out_power_now      = out_set_r.power;
  assign out_mode_now       = out_set_r.mode;
  assign out_frequency_now  = out_set_r.frequency;

endmodule

// File: rtl/vcfc_frame_build.sv
module vcfc_frame_build (
  input  logic [2:0]                 cmd,
  input  logic [15:0]                value,
  input  logic [1:0]                 version,
  output vcfc_pkg::frame_t           frame,
  output logic [vcfc_pkg::LEN_W-1:0] len
);
  import vcfc_pkg::*;

  logic [7:0] cmd_byte;
  logic [7:0] len_byte;
  logic [7:0] p0;
  logic [7:0] p1;
  logic [7:0] c3;
  logic [7:0] c4;
  logic [7:0] c5;
  logic [7:0] c6;

  assign cmd_byte = {4'd0, cmd, 1'b1};
  assign c3 = crc_byte(crc_byte(crc_byte(8'd0, SYNC_BYTE), HDR_BYTE), cmd_byte);
  assign c4 = crc_byte(c3, len_byte);
  assign c5 = crc_byte(c4, p0);
  assign c6 = crc_byte(c5, p1);

  always_comb begin
    len_byte = 8'd0;
    p0       = 8'd0;
    p1       = 8'd0;
    case (cmd)
      CMD_POWER: begin
        len_byte = 8'd1;
        p0       = (version == VER_ONE) ? v1_power(value[1:0]) : value[7:0];
      end
      CMD_CHAN, CMD_MODE: begin
        len_byte = 8'd1;
        p0       = value[7:0];
      end
      CMD_FREQ: begin
        len_byte = 8'd2;
        p0       = value[15:8];
        p1       = value[7:0];
      end
      default: begin
        len_byte = 8'd0;
      end
    endcase
  end

  always_comb begin
    frame    = '0;
    frame[1] = SYNC_BYTE;
    frame[2] = HDR_BYTE;
    frame[3] = cmd_byte;
    len      = LEN_W'(4);
    case (cmd)
      CMD_GET: begin
        frame[4] = len_byte;
        frame[5] = c4;
        len      = LEN_W'(7);
      end
      CMD_POWER, CMD_CHAN: begin
        frame[4] = len_byte;
        frame[5] = p0;
        frame[6] = c5;
        len      = LEN_W'(8);
      end
      CMD_MODE: begin
        // mode exists only on version two units, else header only
        if (version == VER_TWO) begin
          frame[4] = len_byte;
          frame[5] = p0;
          frame[6] = c5;
          len      = LEN_W'(8);
        end
      end
      CMD_FREQ: begin
        frame[4] = len_byte;
        frame[5] = p0;
        frame[6] = p1;
        frame[7] = c6;
        len      = LEN_W'(9);
      end
      default: begin
        len = LEN_W'(4);
      end
    endcase
  end

endmodule

// File: rtl/vcfc_reply_dec.sv
module vcfc_reply_dec #(
  parameter int REPLY_MAX = vcfc_pkg::REPLY_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [2:0]          cmd,
  input  logic [7:0]          rb,
  input  logic                last,
  output vcfc_pkg::settings_t set_cur,
  output vcfc_pkg::settings_t set_nxt,
  output logic                ok
);
  import vcfc_pkg::*;

  localparam int CW = $clog2(REPLY_MAX + 1);

  logic [7:0]    store_r [STORE_DEPTH];
  logic [CW-1:0] count_r;
  logic [7:0]    crc_r;
  settings_t     set_r;
  logic [7:0]    s [STORE_DEPTH];
  logic          framed;
  logic          crc_ok;
  logic          echo_ok;
  logic [1:0]    ver;

  assign set_cur = set_r;

  // final byte overlays its own slot
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      s[i] = (count_r == CW'(i)) ? rb : store_r[i];
    end
  end

  assign framed  = (s[0] == SYNC_BYTE) && (s[1] == HDR_BYTE);
  assign crc_ok  = (rb == crc_r);
  assign echo_ok = framed && (s[2] == {5'd0, cmd}) && (s[3] == {5'd0, cmd}) && crc_ok;

  always_comb begin
    if (s[2] == VER1_CODE) begin
      ver = VER_ONE;
    end else if (s[2] == VER2_CODE) begin
      ver = VER_TWO;
    end else begin
      ver = VER_UNKNOWN;
    end
  end

  always_comb begin
    set_nxt = set_r;
    ok      = 1'b0;
    case (cmd)
      CMD_GET: begin
        if (framed) begin
          set_nxt.version = ver;
          if (ver != VER_UNKNOWN && s[3] >= 8'd2) begin
            set_nxt.channel   = s[4];
            set_nxt.power     = s[5];
            set_nxt.mode      = s[6];
            set_nxt.frequency = {s[7], s[8]};
            ok                = crc_ok;
          end
        end
      end
      CMD_POWER: begin
        if (echo_ok && s[5] == RSV_BYTE) begin
          set_nxt.power = s[4];
          ok            = 1'b1;
        end
      end
      CMD_CHAN: begin
        if (echo_ok && s[5] == RSV_BYTE) begin
          set_nxt.channel = s[4];
          ok              = 1'b1;
        end
      end
      CMD_FREQ: begin
        if (echo_ok && s[6] == RSV_BYTE) begin
          set_nxt.frequency = {s[4], s[5]};
          ok                = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= '0;
      set_r   <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (byte_en) begin
      if (last) begin
        count_r <= '0;
        crc_r   <= '0;
        set_r   <= set_nxt;
        for (int i = 0; i < STORE_DEPTH; i++) begin
          store_r[i] <= '0;
        end
      end else if (count_r < CW'(REPLY_MAX)) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if (count_r == CW'(i)) begin
            store_r[i] <= rb;
          end
        end
        if (count_r >= CW'(2)) begin
          crc_r <= crc_byte(crc_r, rb);
        end
        count_r <= count_r + CW'(1);
      end
    end
  end

endmodule

// File: rtl/vcfc_checker.sv
module vcfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic [2:0]  in_command,
  input logic [15:0] in_value,
  input logic [7:0]  in_reply_byte,
  input logic        in_reply_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_frame_end,
  input logic        out_reply_ok,
  input logic [1:0]  out_device_version,
  input logic [7:0]  out_channel_now,
  input logic [7:0]  out_power_now,
  input logic [7:0]  out_mode_now,
  input logic [15:0] out_frequency_now
);
  import vcfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte)
      && $stable(out_result_kind) && $stable(out_reply_ok))
    else $error("stalled result changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_action) && $stable(in_command)
      && $stable(in_value) && $stable(in_reply_byte) && $stable(in_reply_last))
    else $error("stalled input item changed");

  a_rpt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_RPT |-> out_tx_byte == 8'd0 && !out_frame_end)
    else $error("report carries frame byte");

  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_TX |-> !out_reply_ok
      && out_device_version == VER_UNKNOWN && out_frequency_now == 16'd0
      && out_channel_now == 8'd0 && out_power_now == 8'd0 && out_mode_now == 8'd0)
    else $error("frame byte carries report fields");

  // a non-final reply byte leaves nothing to send, so the next item is taken
  a_reply_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_REPLY && !in_reply_last |=> !in_stall)
    else $error("input stalled after silent reply byte");

endmodule

bind vtx_control_frame_codec_core vcfc_checker u_vcfc_checker (.*);
